@@ rtl/core/dpls_pkg.sv @@
package dpls_pkg;

  typedef enum logic [6:0] {
    BTN_RESET = 7'b0000001,
    BTN_WAIT  = 7'b0000010,
    BTN_LATCH = 7'b0000100,
    BTN_DEB   = 7'b0001000,
    BTN_HELD  = 7'b0010000,
    BTN_LONG  = 7'b0100000,
    BTN_DONE  = 7'b1000000
  } btn_phase_t;

  typedef enum logic [5:0] {
    BLK_RESET  = 6'b000001,
    BLK_IDLE   = 6'b000010,
    BLK_SW_ON  = 6'b000100,
    BLK_ON     = 6'b001000,
    BLK_SW_OFF = 6'b010000,
    BLK_OFF    = 6'b100000
  } blk_phase_t;

  typedef struct packed {
    blk_phase_t  phase;
    logic [31:0] start;
    logic [7:0]  count;
    logic        level;
  } blink_t;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ON   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFF  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CNT  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ON  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_OFF = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CNT = 4'd7;

  localparam logic [7:0]  RST_BOUNCE     = 8'd7;
  localparam logic [15:0] RST_LONG_PRESS = 16'd1000;
  localparam logic [15:0] RST_FIRST_ON   = 16'd1000;
  localparam logic [15:0] RST_FIRST_OFF  = 16'd1000;
  localparam logic [7:0]  RST_FIRST_CNT  = 8'd15;
  localparam logic [15:0] RST_SECOND_ON  = 16'd1500;
  localparam logic [15:0] RST_SECOND_OFF = 16'd500;
  localparam logic [7:0]  RST_SECOND_CNT = 8'd2;

  function automatic blink_t blink_step(blink_t b, logic [31:0] now,
                                        logic [15:0] on_t, logic [15:0] off_t,
                                        logic [7:0] blinks);
    logic [31:0] elapsed;
    blink_t      n;
    elapsed = now - b.start;
    n = b;
    unique case (b.phase)
      BLK_RESET: begin
        n.count = 8'd0;
        n.phase = BLK_IDLE;
      end
      BLK_IDLE: begin
        n.phase = BLK_IDLE;
      end
      BLK_SW_ON: begin
        n.level = 1'b1;
        n.start = now;
        n.phase = BLK_ON;
      end
      BLK_ON: begin
        if (elapsed > {16'd0, on_t}) begin
          n.phase = BLK_SW_OFF;
        end
      end
      BLK_SW_OFF: begin
        n.count = b.count + 8'd1;
        n.start = now;
        n.level = 1'b0;
        n.phase = BLK_OFF;
      end
      BLK_OFF: begin
        if (b.count >= blinks) begin
          n.phase = BLK_RESET;
        end else if (elapsed > {16'd0, off_t}) begin
          n.phase = BLK_SW_ON;
        end
      end
      default: begin
        n.phase = BLK_RESET;
      end
    endcase
    return n;
  endfunction

endpackage

@@ rtl/core/debounced_press_led_blink_sequencer_top.sv @@
// Debounced button press with two blinking LED sequencers.
// Input channel: one transaction per control-loop pass, carrying the button
// level (in_button_down) and a wrapping millisecond timestamp (in_now_ms).
// Result channel: one transaction per input transaction with both LED drive
// levels and a press_done pulse, in input order.
// Config channel: cfg_index selects a register (0..7), cfg_data carries its
// value in the low bits; cfg_ready is always high, indexes above 7 are dropped.
// Write configuration only while no transaction is in flight.
// An accepted transaction enters the input register, and its result then
// enters the result register. Throughput: one transaction per cycle while
// out_stall is low, set by the single compute pass between the two registers.
// A held result (out_stall high) keeps one more transaction in the input
// register; in_stall rises only when both registers are full.
// Reset (rst_n low at a clock edge) clears both pipeline stages, returns all
// machines to their reset phase with LEDs off and restores register defaults.
module debounced_press_led_blink_sequencer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_button_down,
  input  logic [31:0]                          in_now_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_first_led,
  output logic                                 out_second_led,
  output logic                                 out_press_done,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dpls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpls_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [7:0]  bounce_r;
  logic [15:0] long_press_r;
  logic [15:0] first_on_r;
  logic [15:0] first_off_r;
  logic [7:0]  first_cnt_r;
  logic [15:0] second_on_r;
  logic [15:0] second_off_r;
  logic [7:0]  second_cnt_r;

  logic        s1_valid_r;
  logic        s1_down_r;
  logic [31:0] s1_now_r;

  dpls_pkg::btn_phase_t btn_r, btn_nxt;
  logic [31:0]          press_start_r, press_start_nxt;
  dpls_pkg::blink_t     first_r, first_nxt, first_in;
  dpls_pkg::blink_t     second_r, second_nxt, second_in;
  logic                 done_nxt;
  logic [31:0]          held;

  logic out_valid_r;
  logic first_led_r;
  logic second_led_r;
  logic press_done_r;

  logic out_ready;
  logic adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounce_r     <= dpls_pkg::RST_BOUNCE;
      long_press_r <= dpls_pkg::RST_LONG_PRESS;
      first_on_r   <= dpls_pkg::RST_FIRST_ON;
      first_off_r  <= dpls_pkg::RST_FIRST_OFF;
      first_cnt_r  <= dpls_pkg::RST_FIRST_CNT;
      second_on_r  <= dpls_pkg::RST_SECOND_ON;
      second_off_r <= dpls_pkg::RST_SECOND_OFF;
      second_cnt_r <= dpls_pkg::RST_SECOND_CNT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dpls_pkg::CFG_BOUNCE:     bounce_r     <= cfg_data[7:0];
        dpls_pkg::CFG_LONG_PRESS: long_press_r <= cfg_data;
        dpls_pkg::CFG_FIRST_ON:   first_on_r   <= cfg_data;
        dpls_pkg::CFG_FIRST_OFF:  first_off_r  <= cfg_data;
        dpls_pkg::CFG_FIRST_CNT:  first_cnt_r  <= cfg_data[7:0];
        dpls_pkg::CFG_SECOND_ON:  second_on_r  <= cfg_data;
        dpls_pkg::CFG_SECOND_OFF: second_off_r <= cfg_data;
        dpls_pkg::CFG_SECOND_CNT: second_cnt_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign out_ready = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_down_r <= in_button_down;
      s1_now_r  <= in_now_ms;
    end
  end

  assign held = s1_now_r - press_start_r;

  always_comb begin
    btn_nxt         = btn_r;
    press_start_nxt = press_start_r;
    done_nxt        = 1'b0;
    first_in        = first_r;
    second_in       = second_r;
    unique case (btn_r)
      dpls_pkg::BTN_RESET: begin
        btn_nxt = dpls_pkg::BTN_WAIT;
      end
      dpls_pkg::BTN_WAIT: begin
        if (s1_down_r) begin
          btn_nxt = dpls_pkg::BTN_LATCH;
        end
      end
      dpls_pkg::BTN_LATCH: begin
        press_start_nxt = s1_now_r;
        btn_nxt         = dpls_pkg::BTN_DEB;
      end
      dpls_pkg::BTN_DEB: begin
        if (!s1_down_r) begin
          btn_nxt = dpls_pkg::BTN_RESET;
        end else if (held > {24'd0, bounce_r}) begin
          btn_nxt = dpls_pkg::BTN_HELD;
        end
      end
      dpls_pkg::BTN_HELD: begin
        first_in.phase = dpls_pkg::BLK_SW_ON;
        if (held >= {16'd0, long_press_r}) begin
          btn_nxt = dpls_pkg::BTN_LONG;
        end else if (!s1_down_r) begin
          btn_nxt = dpls_pkg::BTN_DONE;
        end
      end
      dpls_pkg::BTN_LONG: begin
        second_in.phase = dpls_pkg::BLK_SW_ON;
        btn_nxt         = dpls_pkg::BTN_DONE;
      end
      dpls_pkg::BTN_DONE: begin
        done_nxt = 1'b1;
        btn_nxt  = dpls_pkg::BTN_RESET;
      end
      default: begin
        btn_nxt = dpls_pkg::BTN_RESET;
      end
    endcase
    first_nxt  = dpls_pkg::blink_step(first_in, s1_now_r, first_on_r, first_off_r,
                                      first_cnt_r);
    second_nxt = dpls_pkg::blink_step(second_in, s1_now_r, second_on_r, second_off_r,
                                      second_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_r         <= dpls_pkg::BTN_RESET;
      press_start_r <= 32'd0;
      first_r       <= '{phase: dpls_pkg::BLK_RESET, start: 32'd0, count: 8'd0,
                         level: 1'b0};
      second_r      <= '{phase: dpls_pkg::BLK_RESET, start: 32'd0, count: 8'd0,
                         level: 1'b0};
    end else if (adv) begin
      btn_r         <= btn_nxt;
      press_start_r <= press_start_nxt;
      first_r       <= first_nxt;
      second_r      <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first_led_r  <= first_nxt.level;
      second_led_r <= second_nxt.level;
      press_done_r <= done_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_first_led  = first_led_r;
  assign out_second_led = second_led_r;
  assign out_press_done = press_done_r;

  a_held_keeps_led_on: assert property (@(posedge clk) disable iff (!rst_n)
    adv && btn_r == dpls_pkg::BTN_HELD |=>
      first_r.level && first_r.phase == dpls_pkg::BLK_ON)
    else $error("LED 1 not on after held pass");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    adv && btn_r == dpls_pkg::BTN_DONE |=> out_valid_r && press_done_r)
    else $error("press_done missing after done phase");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(btn_r) && $stable(press_start_r) && $stable(first_r)
      && $stable(second_r))
    else $error("state moved without a transaction");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  a_long_starts_second: assert property (@(posedge clk) disable iff (!rst_n)
    adv && btn_r == dpls_pkg::BTN_LONG |=>
      second_r.level && btn_r == dpls_pkg::BTN_DONE)
    else $error("long press did not start LED 2");

endmodule

@@ dv/debounced_press_led_blink_sequencer_top_test.sv @@
`timescale 1ns / 100ps

module debounced_press_led_blink_sequencer_top_test;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_PASSES = 78;

  typedef struct packed {
    logic first_led;
    logic second_led;
    logic press_done;
  } led_state_t;

  typedef struct packed {
    logic [15:0] bounce;
    logic [15:0] long_press;
    logic [15:0] on1;
    logic [15:0] off1;
    logic [15:0] blinks1;
    logic [15:0] on2;
    logic [15:0] off2;
    logic [15:0] blinks2;
  } timing_t;

  class blink_scoreboard;
    dpls_pkg::btn_phase_t btn;
    logic [31:0]          press_t0;
    dpls_pkg::blink_t     led1;
    dpls_pkg::blink_t     led2;
    logic [7:0]           bounce_ms;
    logic [15:0]          long_ms;
    logic [15:0]          on1_ms;
    logic [15:0]          off1_ms;
    logic [7:0]           blinks1;
    logic [15:0]          on2_ms;
    logic [15:0]          off2_ms;
    logic [7:0]           blinks2;
    led_state_t           due_leds[$];
    int                   mismatches;
    int                   results;
    int                   presses;

    function new();
      btn = dpls_pkg::BTN_RESET;
      press_t0 = '0;
      led1 = '{dpls_pkg::BLK_RESET, 32'd0, 8'd0, 1'b0};
      led2 = led1;
      bounce_ms = dpls_pkg::RST_BOUNCE;
      long_ms = dpls_pkg::RST_LONG_PRESS;
      on1_ms = dpls_pkg::RST_FIRST_ON;
      off1_ms = dpls_pkg::RST_FIRST_OFF;
      blinks1 = dpls_pkg::RST_FIRST_CNT;
      on2_ms = dpls_pkg::RST_SECOND_ON;
      off2_ms = dpls_pkg::RST_SECOND_OFF;
      blinks2 = dpls_pkg::RST_SECOND_CNT;
      mismatches = 0;
      results = 0;
      presses = 0;
    endfunction

    function void write_reg(logic [dpls_pkg::CFG_IDX_W-1:0] idx,
                            logic [dpls_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        dpls_pkg::CFG_BOUNCE:     bounce_ms = data[7:0];
        dpls_pkg::CFG_LONG_PRESS: long_ms = data;
        dpls_pkg::CFG_FIRST_ON:   on1_ms = data;
        dpls_pkg::CFG_FIRST_OFF:  off1_ms = data;
        dpls_pkg::CFG_FIRST_CNT:  blinks1 = data[7:0];
        dpls_pkg::CFG_SECOND_ON:  on2_ms = data;
        dpls_pkg::CFG_SECOND_OFF: off2_ms = data;
        dpls_pkg::CFG_SECOND_CNT: blinks2 = data[7:0];
        default: ;
      endcase
    endfunction

    function dpls_pkg::blink_t led_pass(dpls_pkg::blink_t b, logic [31:0] now,
                                        logic [15:0] on_ms, logic [15:0] off_ms,
                                        logic [7:0] blinks);
      logic [31:0] elapsed;
      elapsed = now - b.start;
      case (b.phase)
        dpls_pkg::BLK_RESET: begin
          b.count = 8'd0;
          b.phase = dpls_pkg::BLK_IDLE;
        end
        dpls_pkg::BLK_IDLE: ;
        dpls_pkg::BLK_SW_ON: begin
          b.level = 1'b1;
          b.start = now;
          b.phase = dpls_pkg::BLK_ON;
        end
        dpls_pkg::BLK_ON: begin
          if (elapsed > {16'd0, on_ms}) b.phase = dpls_pkg::BLK_SW_OFF;
        end
        dpls_pkg::BLK_SW_OFF: begin
          b.count = b.count + 8'd1;
          b.start = now;
          b.level = 1'b0;
          b.phase = dpls_pkg::BLK_OFF;
        end
        dpls_pkg::BLK_OFF: begin
          if (elapsed > {16'd0, off_ms}) b.phase = dpls_pkg::BLK_SW_ON;
          // reached count wins over expired off interval
          if (b.count >= blinks) b.phase = dpls_pkg::BLK_RESET;
        end
        default: b.phase = dpls_pkg::BLK_RESET;
      endcase
      return b;
    endfunction

    function void note_pass(logic down, logic [31:0] now);
      logic [31:0] held;
      led_state_t  r;
      held = now - press_t0;
      r.press_done = 1'b0;
      case (btn)
        dpls_pkg::BTN_RESET: btn = dpls_pkg::BTN_WAIT;
        dpls_pkg::BTN_WAIT: begin
          if (down) btn = dpls_pkg::BTN_LATCH;
        end
        dpls_pkg::BTN_LATCH: begin
          press_t0 = now;
          btn = dpls_pkg::BTN_DEB;
        end
        dpls_pkg::BTN_DEB: begin
          if (held > {24'd0, bounce_ms}) btn = dpls_pkg::BTN_HELD;
          if (!down) btn = dpls_pkg::BTN_RESET;
        end
        dpls_pkg::BTN_HELD: begin
          led1.phase = dpls_pkg::BLK_SW_ON;
          if (held >= {16'd0, long_ms}) btn = dpls_pkg::BTN_LONG;
          else if (!down) btn = dpls_pkg::BTN_DONE;
        end
        dpls_pkg::BTN_LONG: begin
          led2.phase = dpls_pkg::BLK_SW_ON;
          btn = dpls_pkg::BTN_DONE;
        end
        dpls_pkg::BTN_DONE: begin
          r.press_done = 1'b1;
          btn = dpls_pkg::BTN_RESET;
        end
        default: btn = dpls_pkg::BTN_RESET;
      endcase
      led1 = led_pass(led1, now, on1_ms, off1_ms, blinks1);
      led2 = led_pass(led2, now, on2_ms, off2_ms, blinks2);
      r.first_led = led1.level;
      r.second_led = led2.level;
      due_leds.push_back(r);
    endfunction

    function void check_leds(logic first, logic second, logic done);
      led_state_t want;
      results++;
      if (due_leds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with nothing pending: first=%b second=%b done=%b",
                   results, first, second, done);
        return;
      end
      want = due_leds.pop_front();
      if (want.press_done) presses++;
      if (first !== want.first_led || second !== want.second_led ||
          done !== want.press_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected first=%b second=%b done=%b, got %b %b %b",
                   results, want.first_led, want.second_led, want.press_done,
                   first, second, done);
      end
    endfunction

    function int pending();
      return due_leds.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_button_down = 1'b0;
  logic [31:0]                     in_now_ms = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            out_first_led;
  logic                            out_second_led;
  logic                            out_press_done;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [dpls_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dpls_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  blink_scoreboard sb;
  logic [31:0]     clock_ms = '0;
  int unsigned     span = 1;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              quiet = 0;
  int              setups = 0;

  debounced_press_led_blink_sequencer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_button_down (in_button_down),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_first_led  (out_first_led),
    .out_second_led (out_second_led),
    .out_press_done (out_press_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pass(in_button_down, in_now_ms);
      if (out_valid && !out_stall) sb.check_leds(out_first_led, out_second_led, out_press_done);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
    if (quiet == QUIET_LIMIT) begin
      $display("debounced_press_led_blink_sequencer_top_test NOT OK");
      $finish;
    end
  end

  task automatic send_pass(input logic down, input logic [31:0] stamp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_button_down <= down;
    in_now_ms <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic step_pass(input logic down);
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, span);
    send_pass(down, clock_ms);
  endtask

  task automatic wait_drain();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic put_reg(input logic [dpls_pkg::CFG_IDX_W-1:0] idx,
                         input logic [dpls_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_regs(input timing_t t);
    int unsigned                    stray;
    logic [dpls_pkg::CFG_IDX_W-1:0] stray_idx;
    stray = dpls_pkg::CFG_SECOND_CNT + 1 + $urandom_range(0, 7);
    stray_idx = stray[dpls_pkg::CFG_IDX_W-1:0];
    put_reg(dpls_pkg::CFG_BOUNCE, t.bounce);
    put_reg(dpls_pkg::CFG_LONG_PRESS, t.long_press);
    put_reg(dpls_pkg::CFG_FIRST_ON, t.on1);
    put_reg(dpls_pkg::CFG_FIRST_OFF, t.off1);
    put_reg(dpls_pkg::CFG_FIRST_CNT, t.blinks1);
    put_reg(dpls_pkg::CFG_SECOND_ON, t.on2);
    put_reg(dpls_pkg::CFG_SECOND_OFF, t.off2);
    put_reg(dpls_pkg::CFG_SECOND_CNT, t.blinks2);
    put_reg(stray_idx, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_passes();
    logic [31:0] stamps [25];
    logic        downs [25];
    stamps = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFF2, 32'h0000_000F,
               32'h0000_0010, 32'h0000_0011, 32'h0000_0012, 32'h0000_0014, 32'h0000_0019,
               32'h0000_001A, 32'h0000_0040, 32'h0000_0050, 32'h0000_0060, 32'h0000_0441,
               32'h0000_0450, 32'hFFFF_FE00, 32'hFFFF_FE01, 32'hFFFF_FE0A, 32'h0000_01F0,
               32'h0000_01F1, 32'h0000_01F2, 32'h0000_01F3, 32'h0000_01F4, 32'h0000_01F4};
    downs = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
              1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    for (int i = 0; i < 25; i++) send_pass(downs[i], stamps[i]);
    clock_ms = stamps[24];
    in_valid <= 1'b0;
    wait_drain();
  endtask

  task automatic run_phase(input timing_t t, input int mode, input int quota);
    int          sent;
    int          rest;
    int          hold;
    bit          paused;
    logic [15:0] widest;
    load_regs(t);
    setups++;
    send_idle_pct = (mode == 1) ? 83 : (mode == 3) ? 13 : 0;
    recv_stall_pct = (mode == 2) ? 83 : (mode == 3) ? 13 : 0;
    widest = {8'd0, t.bounce[7:0]};
    if (t.long_press > widest) widest = t.long_press;
    if (t.on1 > widest) widest = t.on1;
    if (t.off1 > widest) widest = t.off1;
    if (t.on2 > widest) widest = t.on2;
    if (t.off2 > widest) widest = t.off2;
    span = widest / 4 + 1;
    if ($urandom_range(0, 1) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * span);
    sent = 0;
    paused = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 9) < 8) begin
        // press/release sequence with random timing
        rest = $urandom_range(1, 30);
        hold = $urandom_range(1, 16);
        for (int k = 0; k < rest && sent < quota; k++) begin
          step_pass(1'b0);
          sent++;
        end
        for (int k = 0; k < hold && sent < quota; k++) begin
          step_pass(1'b1);
          sent++;
        end
      end else begin
        rest = $urandom_range(1, 6);
        for (int k = 0; k < rest && sent < quota; k++) begin
          step_pass(1'($urandom_range(0, 1)));
          sent++;
        end
      end
      if (!paused && sent >= quota / 2) begin
        in_valid <= 1'b0;
        wait_drain();
        paused = 1;
      end
    end
    in_valid <= 1'b0;
    wait_drain();
  endtask

  initial begin
    timing_t t;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_passes();
    t = '{default: 16'h0000};
    run_phase(t, 0, PHASE_PASSES);
    t = '{default: 16'hFFFF};
    run_phase(t, 1, PHASE_PASSES);
    for (int p = 0; p < 8; p++) begin
      t.bounce = {8'($urandom), 8'($urandom_range(0, 12))};
      t.long_press = 16'($urandom_range(0, 60));
      t.on1 = 16'($urandom_range(0, 30));
      t.off1 = 16'($urandom_range(0, 30));
      t.blinks1 = {8'($urandom), 8'($urandom_range(0, 6))};
      t.on2 = 16'($urandom_range(0, 30));
      t.off2 = 16'($urandom_range(0, 30));
      t.blinks2 = {8'($urandom), 8'($urandom_range(0, 6))};
      run_phase(t, (p + 2) % 4, PHASE_PASSES);
    end
    repeat (4) @(posedge clk);
    $display("covered %0d control-loop transactions over %0d timing setups", sb.results, setups);
    $display("incl. all-zero and all-ones timings; %0d completed presses seen", sb.presses);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("debounced_press_led_blink_sequencer_top_test OK");
    else
      $display("debounced_press_led_blink_sequencer_top_test NOT OK");
    $finish;
  end

endmodule
